FILE: hw/rtl/gdc_pkg.sv
// Package for the Gregorian date counter: field widths, operation and
// compare codes, the reset date and the month-length helper.
// No dependencies; every other file of the block uses it.
package gdc_pkg;

    localparam int KIND_W  = 2;
    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 16;
    localparam int ADD_W   = 16;
    localparam int ORDER_W = 2;

    localparam logic [KIND_W-1:0] KIND_SET     = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_ADD     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_COMPARE = 2'd3;

    localparam logic [ORDER_W-1:0] ORDER_EQUAL   = 2'd0;
    localparam logic [ORDER_W-1:0] ORDER_EARLIER = 2'd1;
    localparam logic [ORDER_W-1:0] ORDER_LATER   = 2'd2;

    localparam logic [DAY_W-1:0]   RESET_DAY   = 5'd1;
    localparam logic [MONTH_W-1:0] RESET_MONTH = 4'd1;
    localparam logic [YEAR_W-1:0]  BASE_YEAR   = 16'd1900;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    // Year residues kept next to the year: year mod 100 and (year / 100) mod 4.
    localparam int MOD100_W = 7;
    localparam int CENT4_W  = 2;
    localparam logic [MOD100_W-1:0] RESET_MOD100 = 7'd0;   // 1900 mod 100
    localparam logic [CENT4_W-1:0]  RESET_CENT4  = 2'd3;   // 19 mod 4
    localparam logic [MOD100_W-1:0] LAST_MOD100  = 7'd99;
    localparam logic [MOD100_W-1:0] HUNDRED      = 7'd100;

    // year / 100 is taken as (year * 5243) >> 19, which is exact or one too
    // large for every 16-bit year; a single correction step fixes it.
    localparam int RECIP_W     = 13;
    localparam logic [RECIP_W-1:0] RECIP_100 = 13'd5243;
    localparam int RECIP_SHIFT = 19;
    localparam int PROD_W      = YEAR_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    typedef struct packed {
        logic [DAY_W-1:0]   out_day;
        logic [MONTH_W-1:0] out_month;
        logic [YEAR_W-1:0]  out_year;
        logic               ok;
        logic [ORDER_W-1:0] order;
    } res_t;

    typedef struct packed {
        logic capture;
        logic set_check;
        logic step;
        logic load_result;
    } cmd_t;

    typedef struct packed {
        logic step_done;
    } sts_t;

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] len;
        if (m == FEBRUARY)
        begin
            len = leap ? 5'd29 : 5'd28;
        end
        else if (m inside {4'd4, 4'd6, 4'd9, 4'd11})
        begin
            len = 5'd30;
        end
        else
        begin
            len = 5'd31;
        end
        return len;
    endfunction

endpackage

FILE: hw/rtl/gdc_if.sv
// Valid/ready channel interfaces of the Gregorian date counter.
// Depends on gdc_pkg for the field widths.
interface gdc_req_if;
    logic                          valid;
    logic                          ready;
    logic [gdc_pkg::KIND_W-1:0]    kind;
    logic [gdc_pkg::DAY_W-1:0]     in_day;
    logic [gdc_pkg::MONTH_W-1:0]   in_month;
    logic [gdc_pkg::YEAR_W-1:0]    in_year;
    logic [gdc_pkg::ADD_W-1:0]     days_to_add;

    modport source (output valid, kind, in_day, in_month, in_year, days_to_add,
                    input ready);
    modport sink (input valid, kind, in_day, in_month, in_year, days_to_add,
                  output ready);
endinterface

interface gdc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [gdc_pkg::DAY_W-1:0]     out_day;
    logic [gdc_pkg::MONTH_W-1:0]   out_month;
    logic [gdc_pkg::YEAR_W-1:0]    out_year;
    logic                          ok;
    logic [gdc_pkg::ORDER_W-1:0]   order;

    modport source (output valid, out_day, out_month, out_year, ok, order,
                    input ready);
    modport sink (input valid, out_day, out_month, out_year, ok, order,
                  output ready);
endinterface

FILE: hw/rtl/gregorian_date_counter_top.sv
// Top level of the Gregorian date counter: joins the controller and the
// datapath to the request and response channels. Depends on gdc_pkg,
// gdc_if, gdc_ctrl and gdc_datapath.
//
//   channel  direction  fields
//   req      in         kind, in_day, in_month, in_year, days_to_add
//   rsp      out        out_day, out_month, out_year, ok, order
//
// One request is worked at a time. Compare goes from capture straight to the
// result state, set passes through the set check, and advance and add run the
// one-month-per-cycle step loop, one step for every month boundary crossed.
// Reset is asynchronous and restores 1 January 1900. A result waits in the
// output register; a new request is taken while it is pending, and its own
// result is held back until the register is free.
module gregorian_date_counter_top #(
    parameter int YEAR_BITS = 16,
    parameter int ADD_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    gdc_req_if.sink   req,
    gdc_rsp_if.source rsp
);

    gdc_pkg::cmd_t cmd;
    gdc_pkg::sts_t sts;
    gdc_pkg::res_t res;

    gdc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_kind  (req.kind),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    gdc_datapath #(
        .YEAR_BITS (YEAR_BITS),
        .ADD_BITS  (ADD_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .kind        (req.kind),
        .in_day      (req.in_day),
        .in_month    (req.in_month),
        .in_year     (req.in_year),
        .days_to_add (req.days_to_add),
        .cmd         (cmd),
        .sts         (sts),
        .res         (res)
    );

    assign rsp.out_day   = res.out_day;
    assign rsp.out_month = res.out_month;
    assign rsp.out_year  = res.out_year;
    assign rsp.ok        = res.ok;
    assign rsp.order     = res.order;

endmodule

FILE: hw/rtl/gdc_ctrl.sv
// Controller of the Gregorian date counter: sequences one request at a time
// and owns the result valid flag. Depends on gdc_pkg.
module gdc_ctrl (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    input  logic [gdc_pkg::KIND_W-1:0] req_kind,
    output logic                       req_ready,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output gdc_pkg::cmd_t              cmd,
    input  gdc_pkg::sts_t              sts
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SET    = 2'd1;
    localparam logic [1:0] S_STEP   = 2'd2;
    localparam logic [1:0] S_RESULT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    case (req_kind)
                        gdc_pkg::KIND_SET:     state_next = S_SET;
                        gdc_pkg::KIND_ADVANCE: state_next = S_STEP;
                        gdc_pkg::KIND_ADD:     state_next = S_STEP;
                        default:               state_next = S_RESULT;
                    endcase
                end
            end
            S_SET:
            begin
                cmd.set_check = 1'b1;
                state_next    = S_RESULT;
            end
            S_STEP:
            begin
                cmd.step = 1'b1;
                if (sts.step_done)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // The finished result waits here until the output register is free.
                if (slot_free)
                begin
                    cmd.load_result = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.load_result)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

FILE: hw/rtl/gdc_datapath.sv
// Datapath of the Gregorian date counter: stored date with its year
// residues, the month-by-month stepping unit, set validation, compare and
// the result register. Depends on gdc_pkg.
module gdc_datapath #(
    parameter int YEAR_BITS = 16,
    parameter int ADD_BITS  = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [gdc_pkg::KIND_W-1:0]  kind,
    input  logic [gdc_pkg::DAY_W-1:0]   in_day,
    input  logic [gdc_pkg::MONTH_W-1:0] in_month,
    input  logic [gdc_pkg::YEAR_W-1:0]  in_year,
    input  logic [gdc_pkg::ADD_W-1:0]   days_to_add,
    input  gdc_pkg::cmd_t               cmd,
    output gdc_pkg::sts_t               sts,
    output gdc_pkg::res_t               res
);

    localparam int CW  = (YEAR_BITS > gdc_pkg::YEAR_W) ? YEAR_BITS : gdc_pkg::YEAR_W;
    localparam int NW  = (ADD_BITS < gdc_pkg::ADD_W) ? ADD_BITS : gdc_pkg::ADD_W;
    localparam int WDW = gdc_pkg::ADD_W + 1;
    localparam int QXW = gdc_pkg::YEAR_W + 1;
    localparam logic [CW-1:0] YEAR_MAX = CW'({YEAR_BITS{1'b1}});

    // Stored date.
    logic [gdc_pkg::DAY_W-1:0]    cur_day_reg,    cur_day_next;
    logic [gdc_pkg::MONTH_W-1:0]  cur_month_reg,  cur_month_next;
    logic [YEAR_BITS-1:0]         cur_year_reg,   cur_year_next;
    logic [gdc_pkg::MOD100_W-1:0] cur_mod100_reg, cur_mod100_next;
    logic [gdc_pkg::CENT4_W-1:0]  cur_cent4_reg,  cur_cent4_next;

    // Working date of the stepping unit; the day grows by the whole count.
    logic [WDW-1:0]               w_day_reg,    w_day_next;
    logic [gdc_pkg::MONTH_W-1:0]  w_month_reg,  w_month_next;
    logic [YEAR_BITS-1:0]         w_year_reg,   w_year_next;
    logic [gdc_pkg::MOD100_W-1:0] w_mod100_reg, w_mod100_next;
    logic [gdc_pkg::CENT4_W-1:0]  w_cent4_reg,  w_cent4_next;

    // Captured set fields and the year / 100 estimate.
    logic [gdc_pkg::DAY_W-1:0]    s_day_reg;
    logic [gdc_pkg::MONTH_W-1:0]  s_month_reg;
    logic [gdc_pkg::YEAR_W-1:0]   s_year_reg;
    logic [gdc_pkg::QUOT_W-1:0]   quot_reg;

    logic                         ok_reg,    ok_next;
    logic [gdc_pkg::ORDER_W-1:0]  order_reg, order_next;
    gdc_pkg::res_t                res_reg;

    logic [gdc_pkg::PROD_W-1:0]   prod;
    logic [NW-1:0]                add_n;
    logic [WDW-1:0]               step_n;
    logic [CW-1:0]                cur_year_ext;
    logic [CW-1:0]                in_year_ext;
    logic [gdc_pkg::ORDER_W-1:0]  cmp_order;

    logic [QXW-1:0]               quot_x100;
    logic [QXW:0]                 rem_diff;
    logic                         rem_neg;
    logic [gdc_pkg::MOD100_W-1:0] s_mod100;
    logic [gdc_pkg::QUOT_W-1:0]   s_quot;
    logic                         s_leap;
    logic [CW-1:0]                s_year_ext;
    logic                         s_valid;

    logic                         w_leap;
    logic [gdc_pkg::DAY_W-1:0]    w_len;
    logic                         w_more;
    logic                         w_ovf;

    // Capture-cycle logic.
    assign prod         = gdc_pkg::PROD_W'(in_year) * gdc_pkg::PROD_W'(gdc_pkg::RECIP_100);
    assign add_n        = days_to_add[NW-1:0];
    assign step_n       = (kind == gdc_pkg::KIND_ADVANCE) ? WDW'(1) : WDW'(add_n);
    assign cur_year_ext = CW'(cur_year_reg);
    assign in_year_ext  = CW'(in_year);

    always_comb
    begin
        if (cur_year_ext != in_year_ext)
        begin
            cmp_order = (cur_year_ext < in_year_ext) ? gdc_pkg::ORDER_EARLIER
                                                     : gdc_pkg::ORDER_LATER;
        end
        else if (cur_month_reg != in_month)
        begin
            cmp_order = (cur_month_reg < in_month) ? gdc_pkg::ORDER_EARLIER
                                                   : gdc_pkg::ORDER_LATER;
        end
        else if (cur_day_reg != in_day)
        begin
            cmp_order = (cur_day_reg < in_day) ? gdc_pkg::ORDER_EARLIER
                                               : gdc_pkg::ORDER_LATER;
        end
        else
        begin
            cmp_order = gdc_pkg::ORDER_EQUAL;
        end
    end

    // Set check: correct the quotient estimate, then validate the date.
    assign quot_x100 = QXW'(quot_reg) * QXW'(gdc_pkg::HUNDRED);
    assign rem_diff  = (QXW+1)'(s_year_reg) - (QXW+1)'(quot_x100);
    assign rem_neg   = rem_diff[QXW];
    assign s_mod100  = rem_neg ? (rem_diff[gdc_pkg::MOD100_W-1:0] + gdc_pkg::HUNDRED)
                               : rem_diff[gdc_pkg::MOD100_W-1:0];
    assign s_quot    = rem_neg ? (quot_reg - gdc_pkg::QUOT_W'(1)) : quot_reg;
    assign s_leap    = (s_year_reg[1:0] == 2'd0)
                       && ((s_mod100 != '0) || (s_quot[1:0] == 2'd0));
    assign s_year_ext = CW'(s_year_reg);
    assign s_valid   = (s_month_reg >= gdc_pkg::JANUARY)
                       && (s_month_reg <= gdc_pkg::DECEMBER)
                       && (s_year_ext >= CW'(gdc_pkg::BASE_YEAR))
                       && (s_year_ext <= YEAR_MAX)
                       && (s_day_reg != '0)
                       && (s_day_reg <= gdc_pkg::month_len(s_month_reg, s_leap));

    // One month per cycle.
    assign w_leap = (w_year_reg[1:0] == 2'd0)
                    && ((w_mod100_reg != '0) || (w_cent4_reg == '0));
    assign w_len  = gdc_pkg::month_len(w_month_reg, w_leap);
    assign w_more = w_day_reg > WDW'(w_len);
    assign w_ovf  = w_more && (w_month_reg == gdc_pkg::DECEMBER)
                    && (CW'(w_year_reg) == YEAR_MAX);

    assign sts.step_done = !w_more || w_ovf;

    always_comb
    begin
        cur_day_next    = cur_day_reg;
        cur_month_next  = cur_month_reg;
        cur_year_next   = cur_year_reg;
        cur_mod100_next = cur_mod100_reg;
        cur_cent4_next  = cur_cent4_reg;
        w_day_next      = w_day_reg;
        w_month_next    = w_month_reg;
        w_year_next     = w_year_reg;
        w_mod100_next   = w_mod100_reg;
        w_cent4_next    = w_cent4_reg;
        ok_next         = ok_reg;
        order_next      = order_reg;

        if (cmd.capture)
        begin
            w_day_next    = WDW'(cur_day_reg) + step_n;
            w_month_next  = cur_month_reg;
            w_year_next   = cur_year_reg;
            w_mod100_next = cur_mod100_reg;
            w_cent4_next  = cur_cent4_reg;
            ok_next       = 1'b1;
            order_next    = (kind == gdc_pkg::KIND_COMPARE) ? cmp_order
                                                            : gdc_pkg::ORDER_EQUAL;
        end

        if (cmd.set_check)
        begin
            ok_next = s_valid;
            if (s_valid)
            begin
                cur_day_next    = s_day_reg;
                cur_month_next  = s_month_reg;
                cur_year_next   = s_year_ext[YEAR_BITS-1:0];
                cur_mod100_next = s_mod100;
                cur_cent4_next  = s_quot[gdc_pkg::CENT4_W-1:0];
            end
        end

        if (cmd.step)
        begin
            if (w_ovf)
            begin
                // The stored date stays as it was.
                ok_next = 1'b0;
            end
            else if (w_more)
            begin
                w_day_next = w_day_reg - WDW'(w_len);
                if (w_month_reg == gdc_pkg::DECEMBER)
                begin
                    w_month_next = gdc_pkg::JANUARY;
                    w_year_next  = w_year_reg + YEAR_BITS'(1);
                    if (w_mod100_reg == gdc_pkg::LAST_MOD100)
                    begin
                        w_mod100_next = '0;
                        w_cent4_next  = w_cent4_reg + gdc_pkg::CENT4_W'(1);
                    end
                    else
                    begin
                        w_mod100_next = w_mod100_reg + gdc_pkg::MOD100_W'(1);
                    end
                end
                else
                begin
                    w_month_next = w_month_reg + gdc_pkg::MONTH_W'(1);
                end
            end
            else
            begin
                cur_day_next    = w_day_reg[gdc_pkg::DAY_W-1:0];
                cur_month_next  = w_month_reg;
                cur_year_next   = w_year_reg;
                cur_mod100_next = w_mod100_reg;
                cur_cent4_next  = w_cent4_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_day_reg    <= gdc_pkg::RESET_DAY;
            cur_month_reg  <= gdc_pkg::RESET_MONTH;
            cur_year_reg   <= YEAR_BITS'(gdc_pkg::BASE_YEAR);
            cur_mod100_reg <= gdc_pkg::RESET_MOD100;
            cur_cent4_reg  <= gdc_pkg::RESET_CENT4;
        end
        else
        begin
            cur_day_reg    <= cur_day_next;
            cur_month_reg  <= cur_month_next;
            cur_year_reg   <= cur_year_next;
            cur_mod100_reg <= cur_mod100_next;
            cur_cent4_reg  <= cur_cent4_next;
        end
    end

    always_ff @(posedge clk)
    begin
        w_day_reg    <= w_day_next;
        w_month_reg  <= w_month_next;
        w_year_reg   <= w_year_next;
        w_mod100_reg <= w_mod100_next;
        w_cent4_reg  <= w_cent4_next;
        ok_reg       <= ok_next;
        order_reg    <= order_next;
        if (cmd.capture)
        begin
            s_day_reg   <= in_day;
            s_month_reg <= in_month;
            s_year_reg  <= in_year;
            quot_reg    <= prod[gdc_pkg::PROD_W-1:gdc_pkg::RECIP_SHIFT];
        end
        if (cmd.load_result)
        begin
            res_reg.out_day   <= cur_day_reg;
            res_reg.out_month <= cur_month_reg;
            res_reg.out_year  <= cur_year_ext[gdc_pkg::YEAR_W-1:0];
            res_reg.ok        <= ok_reg;
            res_reg.order     <= order_reg;
        end
    end

    assign res = res_reg;

endmodule

FILE: tb/sv/gregorian_date_counter_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of gregorian_date_counter_top: a directed pass, then random
// traffic under several idle and stall patterns, checked against a built-in date predictor.
// Depends on gdc_pkg, gdc_if and the RTL of the block.
module gregorian_date_counter_top_test;
    import gdc_pkg::*;

    localparam int          CLK_HALF_NS     = 1;
    localparam int          RESET_CYCLES    = 12;
    localparam int          DRAIN_CYCLES    = 20;
    localparam int          HOLD_OFF_CYCLES = 300;
    localparam int          PHASE_ITEMS     = 60;
    localparam int          LIMIT_NS        = 5_000_000;
    localparam int unsigned YEAR_LAST       = (1 << YEAR_W) - 1;
    localparam int unsigned ADD_LAST        = (1 << ADD_W) - 1;
    localparam int unsigned DAYS_PER_400Y   = 146097;

    logic clk = 1'b0;
    logic rst_n;

    gdc_req_if req_bus ();
    gdc_rsp_if rsp_bus ();

    gregorian_date_counter_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Date held by the predictor; it follows every accepted request.
    int unsigned cal_day;
    int unsigned cal_month;
    int unsigned cal_year;
    res_t        date_results_q[$];

    int req_idle_pct  = 0;
    int rsp_stall_pct = 0;
    int rsp_hold_left = 0;
    int fail_count    = 0;

    always
    begin
        #CLK_HALF_NS clk = 1'b1;
        #CLK_HALF_NS clk = 1'b0;
    end

    function automatic bit is_leap_year(int unsigned y);
        return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
    endfunction

    function automatic int unsigned days_in_month(int unsigned m, int unsigned y);
        int unsigned len;
        if (m == FEBRUARY)
        begin
            len = is_leap_year(y) ? 29 : 28;
        end
        else if (m == 4 || m == 6 || m == 9 || m == 11)
        begin
            len = 30;
        end
        else
        begin
            len = 31;
        end
        return len;
    endfunction

    function automatic bit is_valid_date(int unsigned d, int unsigned m, int unsigned y);
        if (m < JANUARY || m > DECEMBER || y < BASE_YEAR || y > YEAR_LAST || d < 1)
        begin
            return 1'b0;
        end
        return d <= days_in_month(m, y);
    endfunction

    // Moves the held date forward by whole 400-year periods, then month by month; leaves it alone on year overflow.
    function automatic bit add_days_to_calendar(int unsigned n);
        int unsigned d;
        int unsigned m;
        int unsigned y;
        int unsigned len;
        y = cal_year + (n / DAYS_PER_400Y) * 400;
        if (y > YEAR_LAST)
        begin
            return 1'b0;
        end
        d = cal_day + n % DAYS_PER_400Y;
        m = cal_month;
        len = days_in_month(m, y);
        while (d > len)
        begin
            d = d - len;
            m = m + 1;
            if (m > DECEMBER)
            begin
                m = JANUARY;
                y = y + 1;
                if (y > YEAR_LAST)
                begin
                    return 1'b0;
                end
            end
            len = days_in_month(m, y);
        end
        cal_day = d;
        cal_month = m;
        cal_year = y;
        return 1'b1;
    endfunction

    function automatic res_t predict_date_step(logic [KIND_W-1:0] kind,
                                               logic [DAY_W-1:0] day,
                                               logic [MONTH_W-1:0] month,
                                               logic [YEAR_W-1:0] year,
                                               logic [ADD_W-1:0] days);
        res_t r;
        r.ok = 1'b1;
        r.order = ORDER_EQUAL;
        case (kind)
            KIND_SET:
            begin
                if (is_valid_date(day, month, year))
                begin
                    cal_day = day;
                    cal_month = month;
                    cal_year = year;
                end
                else
                begin
                    r.ok = 1'b0;
                end
            end
            KIND_ADVANCE:
            begin
                r.ok = add_days_to_calendar(1);
            end
            KIND_ADD:
            begin
                r.ok = add_days_to_calendar(days);
            end
            default:
            begin
                // The given fields are compared as they are, even if not a real date.
                if (cal_year != year)
                begin
                    r.order = (cal_year < year) ? ORDER_EARLIER : ORDER_LATER;
                end
                else if (cal_month != month)
                begin
                    r.order = (cal_month < month) ? ORDER_EARLIER : ORDER_LATER;
                end
                else if (cal_day != day)
                begin
                    r.order = (cal_day < day) ? ORDER_EARLIER : ORDER_LATER;
                end
            end
        endcase
        r.out_day = cal_day[DAY_W-1:0];
        r.out_month = cal_month[MONTH_W-1:0];
        r.out_year = cal_year[YEAR_W-1:0];
        return r;
    endfunction

    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [DAY_W-1:0] day,
                                input logic [MONTH_W-1:0] month,
                                input logic [YEAR_W-1:0] year,
                                input logic [ADD_W-1:0] days);
        @(negedge clk);
        while ($urandom_range(99) < req_idle_pct)
        begin
            req_bus.valid <= 1'b0;
            @(negedge clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.kind <= kind;
        req_bus.in_day <= day;
        req_bus.in_month <= month;
        req_bus.in_year <= year;
        req_bus.days_to_add <= days;
        @(posedge clk);
        while (!req_bus.ready)
        begin
            @(posedge clk);
        end
        date_results_q.push_back(predict_date_step(kind, day, month, year, days));
    endtask

    task automatic send_random_item();
        int unsigned       pick;
        int unsigned       sel;
        int unsigned       d;
        int unsigned       m;
        int unsigned       y;
        int unsigned       n;
        logic [KIND_W-1:0] kind;
        pick = $urandom_range(99);
        d = $urandom_range(31);
        m = $urandom_range(15);
        y = $urandom_range(YEAR_LAST);
        n = $urandom_range(ADD_LAST);
        if (pick < 35)
        begin
            // Well-formed date; a few near the top of the year range to reach overflow.
            kind = KIND_SET;
            sel = $urandom_range(9);
            if (sel < 8)
            begin
                y = $urandom_range(2500, BASE_YEAR);
            end
            else if (sel == 8)
            begin
                y = $urandom_range(YEAR_LAST, YEAR_LAST - 40);
            end
            else
            begin
                y = $urandom_range(YEAR_LAST, BASE_YEAR);
            end
            m = $urandom_range(DECEMBER, JANUARY);
            d = $urandom_range(days_in_month(m, y), 1);
        end
        else if (pick < 40)
        begin
            kind = KIND_SET;
        end
        else if (pick < 55)
        begin
            kind = KIND_ADVANCE;
        end
        else if (pick < 80)
        begin
            // Mostly short counts; long ones keep the month loop busy for a while.
            kind = KIND_ADD;
            sel = $urandom_range(49);
            if (sel < 45)
            begin
                n = $urandom_range(800);
            end
            else if (sel < 49)
            begin
                n = $urandom_range(5000);
            end
        end
        else
        begin
            kind = KIND_COMPARE;
            if ($urandom_range(1) == 1)
            begin
                d = cal_day;
                m = cal_month;
                y = cal_year;
                case ($urandom_range(3))
                    1: d = ($urandom_range(1) == 1) ? d + 1 : d - 1;
                    2: m = ($urandom_range(1) == 1) ? m + 1 : m - 1;
                    3: y = ($urandom_range(1) == 1) ? y + 1 : y - 1;
                    default: ;
                endcase
            end
        end
        send_request(kind, d[DAY_W-1:0], m[MONTH_W-1:0], y[YEAR_W-1:0], n[ADD_W-1:0]);
    endtask

    task automatic test_directed_cases();
        req_idle_pct = 0;
        rsp_stall_pct = 0;
        send_request(KIND_COMPARE, 5'd1, 4'd1, 16'd1900, 16'd0);
        send_request(KIND_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd0);
        send_request(KIND_SET, 5'd0, 4'd1, 16'd2000, 16'd0);
        send_request(KIND_SET, 5'd31, 4'd4, 16'd2001, 16'd0);
        send_request(KIND_SET, 5'd29, 4'd2, 16'd1900, 16'd0);
        send_request(KIND_SET, 5'd1, 4'd0, 16'd2000, 16'd0);
        send_request(KIND_SET, 5'd1, 4'd13, 16'd2000, 16'd0);
        send_request(KIND_SET, 5'd31, 4'd15, 16'd65535, 16'd65535);
        send_request(KIND_SET, 5'd1, 4'd1, 16'd1899, 16'd0);
        send_request(KIND_SET, 5'd29, 4'd2, 16'd2100, 16'd0);
        send_request(KIND_SET, 5'd29, 4'd2, 16'd2000, 16'd0);
        send_request(KIND_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd0);
        send_request(KIND_SET, 5'd28, 4'd2, 16'd2004, 16'd0);
        send_request(KIND_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd0);
        send_request(KIND_ADD, 5'd0, 4'd0, 16'd0, 16'd0);
        send_request(KIND_ADD, 5'd0, 4'd0, 16'd0, 16'd65535);
        send_request(KIND_COMPARE, 5'd31, 4'd15, 16'd65535, 16'd0);
        send_request(KIND_COMPARE, 5'd0, 4'd0, 16'd0, 16'd0);
        send_request(KIND_SET, 5'd31, 4'd12, 16'd65535, 16'd0);
        send_request(KIND_ADVANCE, 5'd0, 4'd0, 16'd0, 16'd0);
        send_request(KIND_ADD, 5'd0, 4'd0, 16'd0, 16'd1);
        send_request(KIND_COMPARE, 5'd31, 4'd12, 16'd65535, 16'd0);
        send_request(KIND_COMPARE, 5'd30, 4'd12, 16'd65535, 16'd0);
        send_request(KIND_COMPARE, 5'd31, 4'd13, 16'd65535, 16'd0);
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int count);
        req_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        repeat (count)
        begin
            send_random_item();
        end
    endtask

    // The output side is held off while requests keep coming, so the block backs up.
    task automatic test_output_holdoff();
        req_idle_pct = 0;
        rsp_stall_pct = 0;
        rsp_hold_left = HOLD_OFF_CYCLES;
        repeat (12)
        begin
            send_random_item();
        end
    endtask

    always @(negedge clk)
    begin
        if (rsp_hold_left > 0)
        begin
            rsp_hold_left = rsp_hold_left - 1;
            rsp_bus.ready <= 1'b0;
        end
        else
        begin
            rsp_bus.ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin : check_results
        res_t want;
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
        begin
            if (date_results_q.size() == 0)
            begin
                $error("result transfer with no request outstanding");
                fail_count++;
            end
            else
            begin
                want = date_results_q.pop_front();
                if (rsp_bus.out_day !== want.out_day)
                begin
                    $error("out_day: expected %0d, got %0d", want.out_day, rsp_bus.out_day);
                    fail_count++;
                end
                if (rsp_bus.out_month !== want.out_month)
                begin
                    $error("out_month: expected %0d, got %0d", want.out_month,
                           rsp_bus.out_month);
                    fail_count++;
                end
                if (rsp_bus.out_year !== want.out_year)
                begin
                    $error("out_year: expected %0d, got %0d", want.out_year, rsp_bus.out_year);
                    fail_count++;
                end
                if (rsp_bus.ok !== want.ok)
                begin
                    $error("ok: expected %0d, got %0d", want.ok, rsp_bus.ok);
                    fail_count++;
                end
                if (rsp_bus.order !== want.order)
                begin
                    $error("order: expected %0d, got %0d", want.order, rsp_bus.order);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        #LIMIT_NS;
        $display("** gregorian_date_counter_top: FAILED **");
        $finish;
    end

    initial
    begin
        rst_n = 1'b0;
        req_bus.valid = 1'b0;
        req_bus.kind = KIND_SET;
        req_bus.in_day = '0;
        req_bus.in_month = '0;
        req_bus.in_year = '0;
        req_bus.days_to_add = '0;
        rsp_bus.ready = 1'b0;
        cal_day = RESET_DAY;
        cal_month = RESET_MONTH;
        cal_year = BASE_YEAR;
        repeat (RESET_CYCLES)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        test_directed_cases();
        test_random_traffic(0, 0, PHASE_ITEMS);
        test_random_traffic(77, 0, PHASE_ITEMS);
        test_random_traffic(0, 77, PHASE_ITEMS);
        test_random_traffic(7, 7, PHASE_ITEMS);
        test_output_holdoff();

        @(negedge clk);
        req_bus.valid <= 1'b0;
        while (date_results_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES)
        begin
            @(posedge clk);
        end
        if (fail_count == 0 && date_results_q.size() == 0)
        begin
            $display("** gregorian_date_counter_top: PASSED **");
        end
        else
        begin
            $display("** gregorian_date_counter_top: FAILED **");
        end
        $finish;
    end

endmodule
